@@ src/fwm_pkg.sv @@
//------------------------------------------------------------------------------
// fwm_pkg
// Shared widths, types and command/status records for the Fox-Wolfram moments block.
//------------------------------------------------------------------------------
`default_nettype none
package fwm_pkg;
	localparam int MomBits  = 20;
	localparam int MaxPart  = 256;
	localparam int IdxBits  = $clog2(MaxPart);
	localparam int CntBits  = $clog2(MaxPart + 1);
	localparam int MagBits  = MomBits + 1;
	localparam int SqBits   = 2 * MomBits + 2;
	localparam int WBits    = 2 * MagBits;
	localparam int DotBits  = 2 * MomBits + 2;
	localparam int SumBits  = 64;
	localparam logic signed [SumBits-1:0] SumLimit = (64'sd1 <<< 62) - 64'sd1;
	localparam logic signed [33:0] Q30One = 34'sd1 <<< 30;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture input word, start magnitude
		logic sqrt_step;  // one step of the root
		logic pair_start; // fetch store entry at index
		logic pair_step;  // advance the pair sequence
		logic clear;      // clear set state
		logic ratio_start;
		logic ratio_step;
		logic write_store;
		logic mark_drop;
	} fwm_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic sqrt_done;
		logic pair_done;
		logic ratio_done;
		logic store_full;
	} fwm_sts_t;
endpackage
`default_nettype wire

@@ src/fwm_ctrl.sv @@
//------------------------------------------------------------------------------
// fwm_ctrl
// Sequencer: accepts a word, steps root, pair loop and ratio division, emits result.
//------------------------------------------------------------------------------
`default_nettype none
module fwm_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic             last_in,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output fwm_pkg::fwm_cmd_t     cmd,
	input  wire fwm_pkg::fwm_sts_t sts
);
	import fwm_pkg::*;

	localparam logic [2:0] StIdle  = 3'd0;
	localparam logic [2:0] StSqrt  = 3'd1;
	localparam logic [2:0] StPair  = 3'd2;
	localparam logic [2:0] StRatio = 3'd3;
	localparam logic [2:0] StOut   = 3'd4;

	logic [2:0] state_q;
	logic       last_q;

	assign in_stall  = (state_q != StIdle);
	assign out_valid = (state_q == StOut);

	// commands decode
	always_comb begin
		cmd = '0;
		case (state_q)
			StIdle: cmd.load = in_valid;
			StSqrt: begin
				cmd.sqrt_step = 1'b1;
				if (sts.sqrt_done) begin
					cmd.write_store = 1'b1;
					cmd.pair_start  = 1'b1;
				end
			end
			StPair: begin
				cmd.pair_step = 1'b1;
				if (sts.pair_done && last_q) cmd.ratio_start = 1'b1;
			end
			StRatio: cmd.ratio_step = 1'b1;
			StOut: cmd.clear = !out_stall;
			default: cmd = '0;
		endcase
		if (state_q == StIdle && in_valid && sts.store_full) cmd.mark_drop = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				StIdle: if (in_valid) begin
					last_q <= last_in;
					if (sts.store_full) begin
						if (last_in) state_q <= StRatio;
					end else begin
						state_q <= StSqrt;
					end
				end
				StSqrt: if (sts.sqrt_done) state_q <= StPair;
				StPair: if (sts.pair_done) state_q <= last_q ? StRatio : StIdle;
				StRatio: if (sts.ratio_done) state_q <= StOut;
				StOut: if (!out_stall) state_q <= StIdle;
				default: state_q <= StIdle;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ src/fwm_dp.sv @@
//------------------------------------------------------------------------------
// fwm_dp
// Datapath: magnitude root, particle store, pair pipeline with a
// bit-serial cosine divider, moment accumulators, ratio divider.
//------------------------------------------------------------------------------
`default_nettype none
module fwm_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic signed [fwm_pkg::MomBits-1:0] mom_x,
	input  wire logic signed [fwm_pkg::MomBits-1:0] mom_y,
	input  wire logic signed [fwm_pkg::MomBits-1:0] mom_z,
	input  wire fwm_pkg::fwm_cmd_t                 cmd,
	output fwm_pkg::fwm_sts_t                      sts,
	output logic [61:0]                            moment_zero,
	output logic signed [31:0]                     ratio_one,
	output logic signed [31:0]                     ratio_two,
	output logic signed [31:0]                     ratio_three,
	output logic signed [31:0]                     ratio_four,
	output logic                                   empty_set,
	output logic                                   dropped_some
);
	import fwm_pkg::*;

	// pair sequence phases
	localparam logic [2:0] PhRead = 3'd0;
	localparam logic [2:0] PhDot  = 3'd1;
	localparam logic [2:0] PhDiv  = 3'd2;
	localparam logic [2:0] PhPow  = 3'd3;
	localparam logic [2:0] PhPoly = 3'd4;
	localparam logic [2:0] PhTerm = 3'd5;
	localparam logic [2:0] PhAcc  = 3'd6;
	localparam logic [2:0] PhWt   = 3'd7;

	// ---------------- input capture and magnitude root ----------------
	logic signed [MomBits-1:0] cx_q, cy_q, cz_q;
	logic [SqBits-1:0] rn_q;
	logic [SqBits-1:0] rr_q;
	logic [SqBits-1:0] rbit_q;
	logic [5:0] rstep_q;
	logic [MagBits-1:0] mag_q;
	logic [MomBits-1:0] ax, ay, az;
	logic [2*MomBits-1:0] sx2, sy2, sz2;
	logic [SqBits-1:0] sq_sum;

	assign ax = mom_x[MomBits-1] ? MomBits'(-mom_x) : MomBits'(mom_x);
	assign ay = mom_y[MomBits-1] ? MomBits'(-mom_y) : MomBits'(mom_y);
	assign az = mom_z[MomBits-1] ? MomBits'(-mom_z) : MomBits'(mom_z);
	assign sx2 = ax * ax;
	assign sy2 = ay * ay;
	assign sz2 = az * az;
	assign sq_sum = SqBits'(sx2) + SqBits'(sy2) + SqBits'(sz2);

	localparam int RootSteps = SqBits / 2;
	logic [SqBits-1:0] rr_ext, rtry;
	// partial root is scaled by the current bit, so it needs the full width
	assign rr_ext = rr_q;
	assign rtry = rr_ext + rbit_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q    <= mom_x;
			cy_q    <= mom_y;
			cz_q    <= mom_z;
			rn_q    <= sq_sum;
			rr_q    <= '0;
			rbit_q  <= SqBits'(1) << (SqBits - 2);
			rstep_q <= '0;
		end else if (cmd.sqrt_step && !sts.sqrt_done) begin
			if (rn_q >= rtry) begin
				rn_q <= rn_q - rtry;
				rr_q <= (rr_ext >> 1) + rbit_q;
			end else begin
				rr_q <= rr_ext >> 1;
			end
			rbit_q  <= rbit_q >> 2;
			rstep_q <= rstep_q + 6'd1;
		end
	end
	assign sts.sqrt_done = (rstep_q == 6'(RootSteps));
	assign mag_q = rr_q[MagBits-1:0];

	// ---------------- particle store ----------------
	logic signed [MomBits-1:0] mem_x [MaxPart];
	logic signed [MomBits-1:0] mem_y [MaxPart];
	logic signed [MomBits-1:0] mem_z [MaxPart];
	logic [MagBits-1:0]        mem_m [MaxPart];
	logic [CntBits-1:0] count_q;
	logic [CntBits-1:0] k_q;
	logic signed [MomBits-1:0] rx_q, ry_q, rz_q;
	logic [MagBits-1:0] rm_q;
	logic drop_q;

	assign sts.store_full = (count_q == CntBits'(MaxPart));

	always_ff @(posedge clk) begin
		if (cmd.write_store) begin
			mem_x[count_q[IdxBits-1:0]] <= cx_q;
			mem_y[count_q[IdxBits-1:0]] <= cy_q;
			mem_z[count_q[IdxBits-1:0]] <= cz_q;
			mem_m[count_q[IdxBits-1:0]] <= mag_q;
		end
		rx_q <= mem_x[k_q[IdxBits-1:0]];
		ry_q <= mem_y[k_q[IdxBits-1:0]];
		rz_q <= mem_z[k_q[IdxBits-1:0]];
		rm_q <= mem_m[k_q[IdxBits-1:0]];
	end

	// ---------------- pair pipeline ----------------
	logic [2:0] ph_q;
	logic [5:0] dstep_q;
	logic signed [DotBits-1:0] px_s1, py_s1, pz_s1;
	logic dneg_q;
	logic [WBits-1:0] w_q;
	logic [DotBits:0] dnum_q;
	logic [30:0] dq_q;
	logic signed [31:0] c_q;
	logic signed [31:0] x2_q, x3_q, x4_q;
	logic [1:0] pw_q;
	logic signed [33:0] pl_q [5];
	logic [2:0] lsel_q;
	logic signed [SumBits-1:0] term_q;
	logic skip_q;
	logic signed [SumBits-1:0] sum_q [5];

	// component products and weight of the pair
	logic signed [2*MomBits-1:0] mx, my, mz;
	logic [WBits-1:0] wm;
	assign mx = cx_q * rx_q;
	assign my = cy_q * ry_q;
	assign mz = cz_q * rz_q;
	assign wm = mag_q * rm_q;

	// Q30 product with rounding half away from zero
	function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic [30:0] ma, mb;
		logic [61:0] p;
		logic [31:0] r;
		ma = a[31] ? 31'(-a) : 31'(a);
		mb = b[31] ? 31'(-b) : 31'(b);
		p  = ma * mb + 62'(1 << 29);
		r  = 32'(p >> 30);
		return (a[31] ^ b[31]) ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [33:0] rsh(input logic signed [36:0] v, input int s);
		logic [36:0] m;
		m = v[36] ? 37'(-v) : 37'(v);
		m = (m + (37'd1 << (s - 1))) >> s;
		return v[36] ? -$signed(34'(m)) : $signed(34'(m));
	endfunction

	logic signed [DotBits-1:0] dot;
	logic [DotBits:0] dabs;
	logic [DotBits:0] dsh;
	assign dot  = px_s1 + py_s1 + pz_s1;
	assign dabs = dot[DotBits-1] ? (DotBits+1)'(-dot) : (DotBits+1)'(dot);
	assign dsh  = {dnum_q[DotBits-1:0], 1'b0};

	// weight times polynomial: w split at bit 30 so each product stays narrow
	logic [32:0] pm;
	logic [29:0] wl;
	logic [WBits-31:0] wh;
	logic [62:0] plo, tlo_s1;
	logic [WBits+2:0] phi, thi_s1;
	logic tneg_s1;
	logic [SumBits-1:0] tmag;
	assign pm = pl_q[lsel_q][33] ? 33'(-pl_q[lsel_q]) : 33'(pl_q[lsel_q]);
	assign wl = w_q[29:0];
	assign wh = w_q[WBits-1:30];
	assign plo = wl * pm;
	assign phi = wh * pm;
	assign tmag = SumBits'(thi_s1) + SumBits'((tlo_s1 + (63'd1 << 29)) >> 30);

	logic signed [SumBits:0] acc_sum;
	assign acc_sum = sum_q[lsel_q] + term_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drop_q  <= 1'b0;
			ph_q    <= PhRead;
			k_q     <= '0;
			for (int l = 0; l < 5; l++) sum_q[l] <= '0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
				drop_q  <= 1'b0;
				for (int l = 0; l < 5; l++) sum_q[l] <= '0;
			end
			if (cmd.mark_drop) drop_q <= 1'b1;
			if (cmd.write_store) count_q <= count_q + 1'b1;
			if (cmd.pair_start) begin
				k_q     <= '0;
				ph_q    <= PhRead;
			end else if (cmd.pair_step) begin
				case (ph_q)
					PhRead: ph_q <= PhDot;
					PhDot: begin
						px_s1 <= DotBits'(mx);
						py_s1 <= DotBits'(my);
						pz_s1 <= DotBits'(mz);
						w_q   <= wm;
						skip_q <= (mag_q == '0) || (rm_q == '0);
						ph_q  <= PhDiv;
						dstep_q <= '0;
						dq_q  <= '0;
						dnum_q <= '1;
					end
					PhDiv: begin
						if (dnum_q == '1 && dstep_q == '0) begin
							dnum_q <= dabs;
							dneg_q <= dot[DotBits-1];
							if (skip_q || dabs >= (DotBits+1)'(w_q)) begin
								dstep_q <= 6'd32;
							end else begin
								dstep_q <= 6'd1;
							end
						end else if (dstep_q == 6'd32) begin
							c_q <= (skip_q || dnum_q >= (DotBits+1)'(w_q)) ?
								(dneg_q ? -32'sd1073741824 : 32'sd1073741824) :
								(dneg_q ? -$signed(({1'b0, dq_q} + 32'd1) >> 1) :
								$signed(({1'b0, dq_q} + 32'd1) >> 1));
							ph_q <= PhPow;
							pw_q <= '0;
						end else begin
							if (dsh >= (DotBits+1)'(w_q)) begin
								dnum_q <= dsh - (DotBits+1)'(w_q);
								dq_q   <= {dq_q[29:0], 1'b1};
							end else begin
								dnum_q <= dsh;
								dq_q   <= {dq_q[29:0], 1'b0};
							end
							dstep_q <= dstep_q + 6'd1;
							if (dstep_q == 6'd31) begin
								dstep_q <= 6'd32;
							end
						end
					end
					PhPow: begin
						case (pw_q)
							2'd0: x2_q <= mulq(c_q, c_q);
							2'd1: begin
								x3_q <= mulq(x2_q, c_q);
								x4_q <= mulq(x2_q, x2_q);
							end
							default: ;
						endcase
						pw_q <= pw_q + 2'd1;
						if (pw_q == 2'd2) ph_q <= PhPoly;
					end
					PhPoly: begin
						pl_q[0] <= Q30One;
						pl_q[1] <= 34'(c_q);
						pl_q[2] <= rsh(37'sd3 * 37'(x2_q) - 37'(Q30One), 1);
						pl_q[3] <= rsh(37'sd5 * 37'(x3_q) - 37'sd3 * 37'(c_q), 1);
						pl_q[4] <= rsh(37'sd35 * 37'(x4_q) - 37'sd30 * 37'(x2_q)
							+ 37'sd3 * 37'(Q30One), 3);
						lsel_q <= '0;
						ph_q <= PhTerm;
					end
					// partial products of weight and polynomial
					PhTerm: begin
						tlo_s1  <= plo;
						thi_s1  <= phi;
						tneg_s1 <= pl_q[lsel_q][33];
						ph_q    <= PhWt;
					end
					PhWt: begin
						term_q <= tneg_s1 ? -$signed(tmag) : $signed(tmag);
						ph_q   <= PhAcc;
					end
					PhAcc: begin
						if (!skip_q) begin
							if (acc_sum > (SumBits+1)'(SumLimit))
								sum_q[lsel_q] <= SumLimit;
							else if (acc_sum < -(SumBits+1)'(SumLimit))
								sum_q[lsel_q] <= -SumLimit;
							else
								sum_q[lsel_q] <= SumBits'(acc_sum);
						end
						if (lsel_q == 3'd4) begin
							k_q  <= k_q + 1'b1;
							ph_q <= PhRead;
						end else begin
							lsel_q <= lsel_q + 3'd1;
							ph_q <= PhTerm;
						end
					end
					default: ph_q <= PhRead;
				endcase
			end
		end
	end
	assign sts.pair_done = cmd.pair_step && ph_q == PhAcc && lsel_q == 3'd4
		&& (k_q + 1'b1 == count_q);

	// ---------------- ratio divider ----------------
	logic [2:0] rsel_q;
	logic [5:0] qstep_q;
	logic [SumBits-1:0] qr_q;
	logic [30:0] qq_q;
	logic signed [31:0] rat_q [4];
	logic rdone_q;
	logic [SumBits-1:0] h0, hab;
	logic hneg;
	logic [SumBits:0] qsh;
	assign h0   = sum_q[0];
	assign hneg = sum_q[rsel_q][SumBits-1];
	assign hab  = hneg ? SumBits'(-sum_q[rsel_q]) : SumBits'(sum_q[rsel_q]);
	assign qsh  = {qr_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdone_q <= 1'b0;
			rsel_q  <= '0;
			qstep_q <= '0;
		end else if (cmd.ratio_start) begin
			rdone_q <= 1'b0;
		end else if (cmd.clear) begin
			rdone_q <= 1'b0;
			rsel_q  <= '0;
			qstep_q <= '0;
		end else if (cmd.ratio_step && !rdone_q) begin
			if (rsel_q == 3'd0) begin
				rsel_q <= 3'd1;
				qstep_q <= '0;
			end else if (qstep_q == 6'd0) begin
				qr_q <= hab;
				qq_q <= '0;
				qstep_q <= 6'd1;
			end else if (qstep_q <= 6'd31) begin
				if (qsh >= (SumBits+1)'(h0)) begin
					qr_q <= SumBits'(qsh - (SumBits+1)'(h0));
					qq_q <= {qq_q[29:0], 1'b1};
				end else begin
					qr_q <= SumBits'(qsh);
					qq_q <= {qq_q[29:0], 1'b0};
				end
				qstep_q <= qstep_q + 6'd1;
			end else begin
				rat_q[rsel_q[1:0] - 2'd1] <=
					(h0[SumBits-1] || h0 == '0) ? 32'sd0 :
					(hab >= h0) ? (hneg ? -32'sd1073741824 : 32'sd1073741824) :
					(hneg ? -$signed(({1'b0, qq_q} + 32'd1) >> 1) :
					$signed(({1'b0, qq_q} + 32'd1) >> 1));
				qstep_q <= '0;
				if (rsel_q == 3'd4) rdone_q <= 1'b1;
				else rsel_q <= rsel_q + 3'd1;
			end
		end
	end
	assign sts.ratio_done = rdone_q;

	assign empty_set    = h0[SumBits-1] || h0 == '0;
	assign moment_zero  = empty_set ? 62'd0 : h0[61:0];
	assign ratio_one    = rat_q[0];
	assign ratio_two    = rat_q[1];
	assign ratio_three  = rat_q[2];
	assign ratio_four   = rat_q[3];
	assign dropped_some = drop_q;
endmodule
`default_nettype wire

@@ src/fox_wolfram_moments.sv @@
//------------------------------------------------------------------------------
// fox_wolfram_moments
// Fox-Wolfram moments H0..H4 over a set of particle momenta.
//------------------------------------------------------------------------------
// Usage: one momentum word (mom_x/y/z, last_particle) is taken per in handshake
// (in_valid high, in_stall low). Each word is stored and paired with itself and
// every stored particle of the set: a magnitude root, then per pair a 31-step
// cosine division, skipped when the cosine saturates or a magnitude is zero.
// in_stall stays high while this work runs, and the next word is taken as soon
// as in_stall is low again.
// A word with last_particle set produces one result word on the out channel
// (out_valid, out_stall) after a further ratio pass.
// The result holds while out_stall is high; set state clears when it is taken.
// Words past 256 particles are dropped and flagged in dropped_some; a dropped
// word is taken with no stall unless it is the last of its set.
// Reset (arst_n low) empties the set and clears all sums; the store itself
// is not cleared and needs no clearing pass.
//------------------------------------------------------------------------------
`default_nettype none
module fox_wolfram_moments (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [fwm_pkg::MomBits-1:0] mom_x,
	input  wire logic signed [fwm_pkg::MomBits-1:0] mom_y,
	input  wire logic signed [fwm_pkg::MomBits-1:0] mom_z,
	input  wire logic                              last_particle,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [61:0]                            moment_zero,
	output logic signed [31:0]                     ratio_one,
	output logic signed [31:0]                     ratio_two,
	output logic signed [31:0]                     ratio_three,
	output logic signed [31:0]                     ratio_four,
	output logic                                   empty_set,
	output logic                                   dropped_some
);
	import fwm_pkg::*;
	fwm_cmd_t cmd;
	fwm_sts_t sts;

	fwm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.last_in(last_particle), .out_valid(out_valid), .out_stall(out_stall),
		.cmd(cmd), .sts(sts)
	);

	fwm_dp u_dp (
		.clk(clk), .arst_n(arst_n), .mom_x(mom_x), .mom_y(mom_y), .mom_z(mom_z),
		.cmd(cmd), .sts(sts), .moment_zero(moment_zero), .ratio_one(ratio_one),
		.ratio_two(ratio_two), .ratio_three(ratio_three), .ratio_four(ratio_four),
		.empty_set(empty_set), .dropped_some(dropped_some)
	);
endmodule
`default_nettype wire

@@ src/fwm_checker.sv @@
//------------------------------------------------------------------------------
// fwm_checker
// Port-level checks of the moments block, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none
module fwm_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic empty_set,
	input wire logic [61:0] moment_zero,
	input wire logic signed [31:0] ratio_one
);
	// no new word taken while a result waits
	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("word accepted with result pending");
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(moment_zero))
		else $error("result changed under stall");
	// empty set reports zero
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_set |-> moment_zero == 62'd0 && ratio_one == 32'sd0)
		else $error("empty set with nonzero result");
	// a result never appears in the cycle after a word is taken
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !out_valid) else $error("result too early");
endmodule

bind fox_wolfram_moments fwm_checker u_fwm_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .empty_set(empty_set),
	.moment_zero(moment_zero), .ratio_one(ratio_one)
);
`default_nettype wire

@@ verif/tb_fox_wolfram_moments.sv @@
//------------------------------------------------------------------------------
// tb_fox_wolfram_moments
// Self-checking bench: streams particle sets into the block with bursty input
// and random output stall, predicts H0 and the H1..H4 ratios for each set in
// fixed point, and compares every result word against the prediction.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_fox_wolfram_moments;
	import fwm_pkg::*;

	localparam longint Q30 = 64'sd1 <<< 30;
	localparam longint SAT = (64'sd1 <<< 62) - 64'sd1;
	localparam longint CYCLE_LIMIT = 40_000_000;
	localparam int DRAIN_CYCLES = 400;

	typedef struct {
		logic signed [MomBits-1:0] px, py, pz;
		logic last;
	} particle_t;

	typedef struct {
		logic [61:0] h0;
		logic signed [31:0] r1, r2, r3, r4;
		logic empty, dropped;
	} moments_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [MomBits-1:0] mom_x = '0, mom_y = '0, mom_z = '0;
	logic last_particle = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [61:0] moment_zero;
	logic signed [31:0] ratio_one, ratio_two, ratio_three, ratio_four;
	logic empty_set, dropped_some;

	fox_wolfram_moments dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mom_x(mom_x), .mom_y(mom_y), .mom_z(mom_z), .last_particle(last_particle),
		.out_valid(out_valid), .out_stall(out_stall),
		.moment_zero(moment_zero), .ratio_one(ratio_one), .ratio_two(ratio_two),
		.ratio_three(ratio_three), .ratio_four(ratio_four),
		.empty_set(empty_set), .dropped_some(dropped_some)
	);

	always #5 clk = ~clk;

	particle_t pending_words[$];
	moments_t expected_moments[$];
	int mismatches = 0;
	longint cycles = 0;

	// set state of the predictor
	longint set_x[MaxPart], set_y[MaxPart], set_z[MaxPart];
	longint unsigned set_mag[MaxPart];
	int set_count = 0;
	longint set_sums[5];
	bit set_dropped = 1'b0;

	//--------------------------------------------------------------------------
	// fixed-point helpers
	//--------------------------------------------------------------------------
	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned mag_of(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint signed_by(bit neg, longint unsigned m);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	// round(num * 2^30 / den), saturated at 2^30
	function automatic longint unsigned div_q30(longint unsigned num, longint unsigned den);
		longint unsigned r, q;
		if (num >= den) return Q30;
		r = num;
		q = 0;
		for (int i = 0; i < 31; i++) begin
			r <<= 1;
			q <<= 1;
			if (r >= den) begin
				r -= den;
				q |= 1;
			end
		end
		return (q + 1) >> 1;
	endfunction

	function automatic longint round_shift(longint v, int s);
		return signed_by(v < 0, (mag_of(v) + (64'd1 << (s - 1))) >> s);
	endfunction

	function automatic longint q30_mul(longint a, longint b);
		return signed_by((a < 0) != (b < 0), (mag_of(a) * mag_of(b) + (64'd1 << 29)) >> 30);
	endfunction

	function automatic longint weighted(longint unsigned w, longint p);
		longint unsigned m, t;
		m = mag_of(p);
		t = (w >> 30) * m + (((w & ((64'd1 << 30) - 1)) * m + (64'd1 << 29)) >> 30);
		return signed_by(p < 0, t);
	endfunction

	// signed Q1.30 ratio of one sum to H0
	function automatic logic signed [31:0] ratio_of(longint h, longint h0);
		return 32'(signed_by(h < 0, div_q30(mag_of(h), longint'(h0))));
	endfunction

	//--------------------------------------------------------------------------
	// predictor: fold one particle into the set, queue a result on the last one
	//--------------------------------------------------------------------------
	task automatic fold_particle(particle_t p);
		longint x, y, z, d, c, x2, x3, x4, s;
		longint leg[5];
		longint unsigned m, w;
		moments_t res;
		x = longint'(p.px);
		y = longint'(p.py);
		z = longint'(p.pz);
		if (set_count < MaxPart) begin
			m = int_sqrt(mag_of(x) * mag_of(x) + mag_of(y) * mag_of(y) + mag_of(z) * mag_of(z));
			set_x[set_count] = x;
			set_y[set_count] = y;
			set_z[set_count] = z;
			set_mag[set_count] = m;
			set_count++;
			for (int k = 0; k < set_count; k++) begin
				if (m != 0 && set_mag[k] != 0) begin
					d = x * set_x[k] + y * set_y[k] + z * set_z[k];
					w = m * set_mag[k];
					c = signed_by(d < 0, div_q30(mag_of(d), w));
					x2 = q30_mul(c, c);
					x3 = q30_mul(x2, c);
					x4 = q30_mul(x2, x2);
					leg[0] = Q30;
					leg[1] = c;
					leg[2] = round_shift(3 * x2 - Q30, 1);
					leg[3] = round_shift(5 * x3 - 3 * c, 1);
					leg[4] = round_shift(35 * x4 - 30 * x2 + 3 * Q30, 3);
					for (int l = 0; l < 5; l++) begin
						s = set_sums[l] + weighted(w, leg[l]);
						if (s > SAT) s = SAT;
						if (s < -SAT) s = -SAT;
						set_sums[l] = s;
					end
				end
			end
		end else begin
			set_dropped = 1'b1;
		end
		if (p.last) begin
			res = '{default: '0};
			if (set_sums[0] <= 0) begin
				res.empty = 1'b1;
			end else begin
				res.h0 = 62'(set_sums[0]);
				res.r1 = ratio_of(set_sums[1], set_sums[0]);
				res.r2 = ratio_of(set_sums[2], set_sums[0]);
				res.r3 = ratio_of(set_sums[3], set_sums[0]);
				res.r4 = ratio_of(set_sums[4], set_sums[0]);
			end
			res.dropped = set_dropped;
			expected_moments = {expected_moments, res};
			set_count = 0;
			set_dropped = 1'b0;
			for (int l = 0; l < 5; l++) set_sums[l] = 0;
		end
	endtask

	//--------------------------------------------------------------------------
	// stimulus helpers
	//--------------------------------------------------------------------------
	task automatic add_word(longint x, longint y, longint z, bit last);
		particle_t p;
		p.px = MomBits'(x);
		p.py = MomBits'(y);
		p.pz = MomBits'(z);
		p.last = last;
		pending_words = {pending_words, p};
	endtask

	function automatic longint pick_component();
		case ($urandom_range(0, 4))
			0: return longint'($signed(20'($urandom)));
			1: return longint'($urandom_range(0, 127)) - 64;
			2: return $urandom_range(0, 1) ? 524287 : -524288;
			3: return 0;
			default: return longint'($urandom_range(0, 8191)) - 4096;
		endcase
	endfunction

	task automatic add_random_set(int n);
		longint bx, by, bz, f;
		bx = pick_component();
		by = pick_component();
		bz = pick_component();
		for (int i = 0; i < n; i++) begin
			// some sets are scaled copies of one direction: exact and reversed cosines
			if ($urandom_range(0, 3) == 0) begin
				f = longint'($urandom_range(0, 4)) - 2;
				add_word(bx * f / 2, by * f / 2, bz * f / 2, i == n - 1);
			end else begin
				add_word(pick_component(), pick_component(), pick_component(), i == n - 1);
			end
		end
	endtask

	//--------------------------------------------------------------------------
	// driver: bursts with gaps, payload held while stalled
	//--------------------------------------------------------------------------
	logic word_taken = 1'b0;
	int burst_left = 1, gap_left = 0;

	always @(posedge clk) word_taken <= in_valid && !in_stall;

	always @(negedge clk) begin
		if (arst_n && (!in_valid || word_taken)) begin
			if (gap_left > 0 || pending_words.size() == 0) begin
				in_valid <= 1'b0;
				if (gap_left > 0) gap_left <= gap_left - 1;
			end else begin
				particle_t p;
				p = pending_words.pop_front();
				in_valid <= 1'b1;
				mom_x <= p.px;
				mom_y <= p.py;
				mom_z <= p.pz;
				last_particle <= p.last;
				if (burst_left <= 1) begin
					burst_left <= int'($urandom_range(1, 8));
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 40));
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// receiver stall: mode switches between none, random and long holds
	int stall_mode = 0;
	always @(negedge clk) begin
		if (cycles % 64 == 0) stall_mode <= int'($urandom_range(0, 2));
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= 1'($urandom_range(0, 1));
			default: out_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	//--------------------------------------------------------------------------
	// monitor: predict on accepted input, check accepted results
	//--------------------------------------------------------------------------
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (in_valid && !in_stall) begin
			particle_t p;
			p.px = mom_x;
			p.py = mom_y;
			p.pz = mom_z;
			p.last = last_particle;
			fold_particle(p);
		end
		if (out_valid && !out_stall) begin
			if (expected_moments.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word h0=%0d", moment_zero);
			end else begin
				moments_t e;
				e = expected_moments.pop_front();
				if (moment_zero !== e.h0 || ratio_one !== e.r1 || ratio_two !== e.r2 ||
						ratio_three !== e.r3 || ratio_four !== e.r4 ||
						empty_set !== e.empty || dropped_some !== e.dropped) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch exp h0=%0d r=%0d %0d %0d %0d e=%b d=%b",
							" got h0=%0d r=%0d %0d %0d %0d e=%b d=%b"},
							e.h0, e.r1, e.r2, e.r3, e.r4, e.empty, e.dropped,
							moment_zero, ratio_one, ratio_two, ratio_three, ratio_four,
							empty_set, dropped_some);
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	//--------------------------------------------------------------------------
	// test sequence
	//--------------------------------------------------------------------------
	initial begin
		int items;
		for (int l = 0; l < 5; l++) set_sums[l] = 0;

		// directed: empty set, extremes, parallel / antiparallel / orthogonal pairs
		add_word(0, 0, 0, 1);
		add_word(524287, 524287, 524287, 1);
		add_word(-524288, -524288, -524288, 0);
		add_word(524287, 524287, 524287, 1);
		add_word(-524288, 0, 0, 0);
		add_word(0, 524287, 0, 0);
		add_word(0, 0, -524288, 1);
		add_word(100, 0, 0, 0);
		add_word(0, 0, 0, 0);
		add_word(-100, 0, 0, 1);
		add_word(3, 4, 0, 0);
		add_word(6, 8, 0, 0);
		add_word(-4, 3, 0, 1);
		add_word(1, 0, 0, 0);
		add_word(0, 1, 1, 1);
		add_word(0, 0, 0, 0);
		add_word(0, 0, 0, 1);
		add_word(1, -1, 1, 1);
		items = pending_words.size();

		// random sets, one of them past the store depth
		while (items < 1150) begin
			int n;
			if (items > 400 && items < 420) n = MaxPart + 4;
			else n = $urandom_range(1, 6);
			add_random_set(n);
			items += n;
		end

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_words.size() != 0 || in_valid || expected_moments.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_moments.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire
